FILE: hdl/m64h_pkg.sv
`default_nettype none

package m64h_pkg;

   localparam int unsigned MAX_WORDS = 65535;

   localparam logic [63:0] MUR_M    = 64'hc6a4a7935bd1e995;
   localparam logic [31:0] MUR_M_LO = MUR_M[31:0];
   localparam logic [31:0] MUR_M_HI = MUR_M[63:32];
   localparam int unsigned MUR_R    = 47;

   // Partial-product steps of one 64-bit multiply.
   localparam logic [1:0] MUL_STEP_LL   = 2'd0;
   localparam logic [1:0] MUL_STEP_LH   = 2'd1;
   localparam logic [1:0] MUL_STEP_LAST = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SEED_W,
      ST_PAIR,
      ST_BLK1_W,
      ST_BLK2_W,
      ST_BLK3_W,
      ST_LAST,
      ST_TAIL_W,
      ST_FINAL,
      ST_FIN_W,
      ST_OUT_ZERO,
      ST_OUT_HASH
   } state_type;

   // Operand that is loaded into the multiplier when it starts.
   typedef enum logic [2:0] {
      OP_SEED,
      OP_BLOCK,
      OP_MIXK,
      OP_MIXH,
      OP_TAIL,
      OP_FIN
   } op_type;

   typedef struct packed {
      logic   capture;
      logic   start;
      op_type op;
      logic   hash_load;
      logic   held_load;
      logic   out_load;
      logic   out_zero;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last;
      logic mul_busy;
      logic mul_done;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/m64h_mul.sv
`default_nettype none

module m64h_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] operand,
   output logic             busy,
   output logic             done,
   output logic [63:0]      product
);
   import m64h_pkg::*;

   logic [63:0] a_ff;
   logic [63:0] prod_ff, prod_in;
   logic [1:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] mul_x, mul_y;
   logic [63:0] partial;

   // The product is taken modulo 2^64, so only the low-low product is needed
   // in full; the two cross products add their low halves into the top word.
   always_comb begin
      case (step_ff)
         MUL_STEP_LL: begin
            mul_x = a_ff[31:0];
            mul_y = MUR_M_LO;
         end
         MUL_STEP_LH: begin
            mul_x = a_ff[31:0];
            mul_y = MUR_M_HI;
         end
         default: begin
            mul_x = a_ff[63:32];
            mul_y = MUR_M_LO;
         end
      endcase
      partial = {32'b0, mul_x} * {32'b0, mul_y};
   end

   always_comb begin
      prod_in = prod_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         step_in = MUL_STEP_LL;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (step_ff == MUL_STEP_LL) begin
            prod_in = partial;
         end else begin
            prod_in = {prod_ff[63:32] + partial[31:0], prod_ff[31:0]};
         end
         step_in = step_ff + 2'd1;
         if (step_ff == MUL_STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= operand;
      end
      prod_ff <= prod_in;
      step_ff <= step_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy    = busy_ff;
   assign done    = done_ff;
   assign product = prod_ff;

endmodule

`default_nettype wire

FILE: hdl/m64h_dpath.sv
`default_nettype none

module m64h_dpath #(
   parameter int unsigned MAX_WORDS = m64h_pkg::MAX_WORDS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire m64h_pkg::cmd_type    cmd,
   output m64h_pkg::status_type      status,
   input  wire logic [31:0]          req_word,
   input  wire logic [15:0]          req_length_words,
   input  wire logic                 req_last,
   output logic [63:0]               rsp_hash
);
   import m64h_pkg::*;

   logic [31:0] word_ff;
   logic [15:0] count_ff;
   logic        last_ff;
   logic [31:0] held_ff;
   logic [63:0] hash_ff;
   logic [63:0] rsp_hash_ff, rsp_hash_in;
   logic [63:0] operand;
   logic [31:0] count_wide;
   logic [31:0] count_sat;
   logic        mul_busy;
   logic        mul_done;
   logic [63:0] product;

   assign count_wide = {16'b0, count_ff};
   assign count_sat  = (count_wide > 32'(MAX_WORDS)) ? 32'(MAX_WORDS) : count_wide;

   always_comb begin
      unique case (cmd.op)
         OP_SEED:  operand = {32'b0, count_sat[29:0], 2'b00};
         OP_BLOCK: operand = {word_ff, held_ff};
         OP_MIXK:  operand = product ^ (product >> MUR_R);
         OP_MIXH:  operand = hash_ff ^ product;
         OP_TAIL:  operand = hash_ff ^ {32'b0, held_ff};
         OP_FIN:   operand = hash_ff ^ (hash_ff >> MUR_R);
         default:  operand = hash_ff;
      endcase
   end

   m64h_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.start),
      .operand (operand),
      .busy    (mul_busy),
      .done    (mul_done),
      .product (product)
   );

   // The last shift of the avalanche is applied as the result is registered.
   assign rsp_hash_in = cmd.out_zero ? 64'b0 : (product ^ (product >> MUR_R));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         word_ff  <= req_word;
         count_ff <= req_length_words;
         last_ff  <= req_last;
      end
      if (cmd.held_load) begin
         held_ff <= word_ff;
      end
      if (cmd.hash_load) begin
         hash_ff <= product;
      end
      if (cmd.out_load) begin
         rsp_hash_ff <= rsp_hash_in;
      end
   end

   assign status.count_zero = (count_ff == 16'd0);
   assign status.last       = last_ff;
   assign status.mul_busy   = mul_busy;
   assign status.mul_done   = mul_done;
   assign rsp_hash          = rsp_hash_ff;

endmodule

`default_nettype wire

FILE: hdl/m64h_ctrl.sv
`default_nettype none

module m64h_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output m64h_pkg::cmd_type         cmd,
   input  wire m64h_pkg::status_type status
);
   import m64h_pkg::*;

   state_type state_ff, state_in;
   logic      in_msg_ff, in_msg_in;
   logic      have_held_ff, have_held_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !(rsp_valid_ff && rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (in_msg_ff) begin
               state_in = ST_PAIR;
            end else if (status.count_zero) begin
               state_in = ST_OUT_ZERO;
            end else begin
               state_in = ST_SEED_W;
            end
         end
         ST_SEED_W: if (status.mul_done) state_in = ST_PAIR;
         ST_PAIR:   state_in = have_held_ff ? ST_BLK1_W : ST_LAST;
         ST_BLK1_W: if (status.mul_done) state_in = ST_BLK2_W;
         ST_BLK2_W: if (status.mul_done) state_in = ST_BLK3_W;
         ST_BLK3_W: if (status.mul_done) state_in = ST_LAST;
         ST_LAST: begin
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (have_held_ff) begin
               state_in = ST_TAIL_W;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_TAIL_W:   if (status.mul_done) state_in = ST_FINAL;
         ST_FINAL:    state_in = ST_FIN_W;
         ST_FIN_W:    if (status.mul_done) state_in = ST_OUT_HASH;
         ST_OUT_ZERO: if (slot_free) state_in = ST_IDLE;
         ST_OUT_HASH: if (slot_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = OP_SEED;
      in_msg_in    = in_msg_ff;
      have_held_in = have_held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE:   cmd.capture = req_valid;
         ST_DECODE: begin
            if (!in_msg_ff && !status.count_zero) begin
               cmd.start = 1'b1;
               cmd.op    = OP_SEED;
            end
         end
         ST_SEED_W: begin
            if (status.mul_done) begin
               cmd.hash_load = 1'b1;
               in_msg_in     = 1'b1;
               have_held_in  = 1'b0;
            end
         end
         ST_PAIR: begin
            if (have_held_ff) begin
               cmd.start = 1'b1;
               cmd.op    = OP_BLOCK;
            end else begin
               cmd.held_load = 1'b1;
               have_held_in  = 1'b1;
            end
         end
         ST_BLK1_W: begin
            cmd.start = status.mul_done;
            cmd.op    = OP_MIXK;
         end
         ST_BLK2_W: begin
            cmd.start = status.mul_done;
            cmd.op    = OP_MIXH;
         end
         ST_BLK3_W: begin
            if (status.mul_done) begin
               cmd.hash_load = 1'b1;
               have_held_in  = 1'b0;
            end
         end
         ST_LAST: begin
            cmd.start = status.last && have_held_ff;
            cmd.op    = OP_TAIL;
         end
         ST_TAIL_W: cmd.hash_load = status.mul_done;
         ST_FINAL: begin
            cmd.start = 1'b1;
            cmd.op    = OP_FIN;
         end
         ST_FIN_W: begin
         end
         ST_OUT_ZERO, ST_OUT_HASH: begin
            if (slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_zero = (state_ff == ST_OUT_ZERO);
               rsp_valid_in = 1'b1;
               in_msg_in    = 1'b0;
               have_held_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_msg_ff    <= 1'b0;
         have_held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_msg_ff    <= in_msg_in;
         have_held_ff <= have_held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A result must never overwrite one that the receiver is still stalling.
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register loaded while a stalled beat is pending");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !status.mul_busy)
      else $error("multiplier started while busy");

   a_held_in_msg: assert property (@(posedge clock) disable iff (reset)
      have_held_ff |-> in_msg_ff)
      else $error("held word outside an open message");

   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_DECODE))
      else $error("accepted beat not decoded");

endmodule

`default_nettype wire

FILE: hdl/murmur64a_word_stream_hash_unit.sv
`default_nettype none

// Streaming MurmurHash64A (seed zero) over messages of 32-bit words.
// Request channel (req_): one beat per word. The first beat of a message
// carries the word count in req_length_words; req_last closes the message.
// A first beat with a count of zero is an empty message and returns hash 0.
// Response channel (rsp_): one beat with the 64-bit hash per message.
// One beat is worked at a time; req_stall is high from acceptance until the
// beat is fully processed. All 64-bit multiplies run on one 32x32 multiplier,
// three partial products per multiply. A beat that completes a word pair
// runs three multiplies, and one that only holds its word runs none. The first
// beat adds the seed multiply and the last beat adds the multiply of the
// avalanche, plus one for an odd word. An empty message runs no multiply.
// The response sits in an output register; while rsp_stall holds it, work on
// the next beat goes on and only a second result waits for the slot.
// Reset (synchronous, active high) closes any open message and drops any
// pending response.
module murmur64a_word_stream_hash_unit #(
   parameter int unsigned MAX_WORDS = m64h_pkg::MAX_WORDS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_word,
   input  wire logic [15:0] req_length_words,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_hash
);
   import m64h_pkg::*;

   cmd_type    cmd;
   status_type status;

   m64h_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   m64h_dpath #(
      .MAX_WORDS (MAX_WORDS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_word         (req_word),
      .req_length_words (req_length_words),
      .req_last         (req_last),
      .rsp_hash         (rsp_hash)
   );

endmodule

`default_nettype wire
